[design/pas_pkg.sv]
// pas_pkg: types and constants for the positional array store with sort
// request and response payload structs, operation and status codes, state codes
// no dependencies
package pas_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int VALUE_W      = 32;
   localparam int POS_W        = 7;
   localparam int COUNT_W      = 7;

   typedef enum logic [2:0] {
      KIND_APPEND = 3'd0,
      KIND_INSERT = 3'd1,
      KIND_DELETE = 3'd2,
      KIND_SORT   = 3'd3,
      KIND_DUMP   = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2,
      STATUS_EMPTY = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_INS_RD,
      ST_INS_WR,
      ST_INS_PUT,
      ST_DEL_CAP,
      ST_DEL_RD,
      ST_DEL_WR,
      ST_SRT_NEXT,
      ST_SRT_KEY,
      ST_SRT_RD,
      ST_SRT_CMP,
      ST_SRT_PUT,
      ST_DMP_RD,
      ST_DMP_EMIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      kind_type                   kind;
      logic signed [VALUE_W-1:0]  value;
      logic [POS_W-1:0]           position;
   } req_type;

   typedef struct packed {
      status_type                 status;
      logic signed [VALUE_W-1:0]  element;
      logic [COUNT_W-1:0]         entry_count;
      logic                       last;
   } rsp_type;

endpackage

[design/positional_array_store_with_sort.sv]
// positional_array_store_with_sort: ordered store of signed values in one memory
// append, insert, delete, insertion sort and dump run as memory read/write sequences
// depends on pas_pkg
//
//   channel   signals                              direction
//   request   req_valid, req_ready, req_payload    in
//   response  rsp_valid, rsp_ready, rsp_payload    out
//
// one request at a time; append and rejected requests go from decode to finish
// insert shifts entries at and above the position up by one, then writes the value;
// delete captures the element, then shifts later entries down by one; sort is an
// insertion sort over the memory; dump emits every entry, stalling on rsp_ready
// reset clears the state, the count and rsp_valid; the memory is not cleared
// a finished response waits in the output register while the next request is accepted
module positional_array_store_with_sort #(
   parameter int CAPACITY = pas_pkg::CAPACITY_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pas_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pas_pkg::rsp_type rsp_payload
);
   import pas_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

   logic [VALUE_W-1:0] mem [CAPACITY];

   state_type                 state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [CW-1:0]             idx_ff, idx_in;
   logic [CW-1:0]             jdx_ff, jdx_in;
   req_type                   req_ff, req_in;
   logic signed [VALUE_W-1:0] key_ff, key_in;
   logic signed [VALUE_W-1:0] element_ff, element_in;
   status_type                status_ff, status_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;
   logic signed [VALUE_W-1:0] rd_data_ff;

   logic               rd_en, wr_en;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic               out_free;
   logic [XW-1:0]      pos_x, cnt_x;

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign pos_x       = XW'(req_ff.position);
   assign cnt_x       = XW'(count_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      jdx_in       = jdx_ff;
      req_in       = req_ff;
      key_in       = key_ff;
      element_in   = element_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            status_in  = STATUS_OK;
            element_in = '0;
            state_in   = ST_FINISH;
            case (req_ff.kind)
               KIND_APPEND: begin
                  if (count_ff >= CAP_CNT) begin
                     status_in = STATUS_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = AW'(count_ff);
                     wr_data  = req_ff.value;
                     count_in = count_ff + CW'(1);
                  end
               end
               KIND_INSERT: begin
                  if (count_ff >= CAP_CNT) begin
                     status_in = STATUS_FULL;
                  end else if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
                     status_in = STATUS_RANGE;
                  end else begin
                     idx_in   = count_ff;
                     state_in = ST_INS_RD;
                  end
               end
               KIND_DELETE: begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end else if (pos_x == '0 || pos_x > cnt_x) begin
                     status_in = STATUS_RANGE;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = AW'(pos_x - XW'(1));
                     idx_in   = CW'(pos_x - XW'(1));
                     state_in = ST_DEL_CAP;
                  end
               end
               KIND_SORT: begin
                  idx_in   = CW'(1);
                  state_in = ST_SRT_NEXT;
               end
               KIND_DUMP: begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     idx_in   = '0;
                     state_in = ST_DMP_RD;
                  end
               end
               default: begin
                  status_in = STATUS_OK;
               end
            endcase
         end
         ST_INS_RD: begin
            if (XW'(idx_ff) >= pos_x) begin
               rd_en    = 1'b1;
               rd_addr  = AW'(idx_ff - CW'(1));
               state_in = ST_INS_WR;
            end else begin
               state_in = ST_INS_PUT;
            end
         end
         ST_INS_WR: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(idx_ff);
            wr_data  = rd_data_ff;
            idx_in   = idx_ff - CW'(1);
            state_in = ST_INS_RD;
         end
         ST_INS_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(pos_x - XW'(1));
            wr_data  = req_ff.value;
            count_in = count_ff + CW'(1);
            state_in = ST_FINISH;
         end
         ST_DEL_CAP: begin
            element_in = rd_data_ff;
            state_in   = ST_DEL_RD;
         end
         ST_DEL_RD: begin
            if (XW'(idx_ff) + XW'(1) < cnt_x) begin
               rd_en    = 1'b1;
               rd_addr  = AW'(idx_ff + CW'(1));
               state_in = ST_DEL_WR;
            end else begin
               count_in = count_ff - CW'(1);
               state_in = ST_FINISH;
            end
         end
         ST_DEL_WR: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(idx_ff);
            wr_data  = rd_data_ff;
            idx_in   = idx_ff + CW'(1);
            state_in = ST_DEL_RD;
         end
         ST_SRT_NEXT: begin
            if (idx_ff < count_ff) begin
               rd_en    = 1'b1;
               rd_addr  = AW'(idx_ff);
               jdx_in   = idx_ff;
               state_in = ST_SRT_KEY;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SRT_KEY: begin
            key_in   = rd_data_ff;
            state_in = ST_SRT_RD;
         end
         ST_SRT_RD: begin
            if (jdx_ff != '0) begin
               rd_en    = 1'b1;
               rd_addr  = AW'(jdx_ff - CW'(1));
               state_in = ST_SRT_CMP;
            end else begin
               state_in = ST_SRT_PUT;
            end
         end
         ST_SRT_CMP: begin
            if (key_ff < rd_data_ff) begin
               wr_en    = 1'b1;
               wr_addr  = AW'(jdx_ff);
               wr_data  = rd_data_ff;
               jdx_in   = jdx_ff - CW'(1);
               state_in = ST_SRT_RD;
            end else begin
               state_in = ST_SRT_PUT;
            end
         end
         ST_SRT_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(jdx_ff);
            wr_data  = key_ff;
            idx_in   = idx_ff + CW'(1);
            state_in = ST_SRT_NEXT;
         end
         ST_DMP_RD: begin
            rd_en    = 1'b1;
            rd_addr  = AW'(idx_ff);
            state_in = ST_DMP_EMIT;
         end
         ST_DMP_EMIT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = STATUS_OK;
               rsp_in.element     = rd_data_ff;
               rsp_in.entry_count = COUNT_W'(count_ff);
               rsp_in.last        = ((idx_ff + CW'(1)) == count_ff);
               idx_in             = idx_ff + CW'(1);
               state_in           = rsp_in.last ? ST_IDLE : ST_DMP_RD;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = status_ff;
               rsp_in.element     = element_ff;
               rsp_in.entry_count = COUNT_W'(count_ff);
               rsp_in.last        = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      jdx_ff     <= jdx_in;
      req_ff     <= req_in;
      key_ff     <= key_in;
      element_ff <= element_in;
      status_ff  <= status_in;
      rsp_ff     <= rsp_in;
   end

   // single write port, single registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("entry count above capacity");

   a_wr_addr_bound: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CW'(wr_addr) < CAP_CNT))
      else $error("memory write outside capacity");

   a_idle_count_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |=> (count_ff == $past(count_ff)))
      else $error("count changed while idle");

   a_dump_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DMP_EMIT) |-> (idx_ff < count_ff))
      else $error("dump index past entry count");

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DECODE))
      else $error("request accepted without decode");

endmodule

[bench/positional_array_store_with_sort_tb.sv]
// positional_array_store_with_sort_tb: self-checking bench for the positional array store
// drives append, insert, delete, sort and dump requests and checks every response in order
// depends on pas_pkg and positional_array_store_with_sort
module positional_array_store_with_sort_tb;
   import pas_pkg::*;

   localparam int CAP        = CAPACITY_DEF;
   localparam int HOLD_LEN   = 400;
   localparam int TAIL_WAIT  = 300;
   localparam int MAX_PRINTS = 40;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   req_type feed_q[$];
   rsp_type pending_rsp[$];

   logic signed [VALUE_W-1:0] store_mirror[CAP];
   int store_count = 0;
   int gen_count   = 0;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_req      = 0;
   int hold_taken    = 0;
   int hold_left     = 0;

   int errors    = 0;
   int n_req     = 0;
   int n_rsp     = 0;
   int n_dump    = 0;
   int max_count = 0;
   int status_seen[4] = '{0, 0, 0, 0};

   positional_array_store_with_sort #(
      .CAPACITY(CAP)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #10 clock = ~clock;

   initial begin
      #100_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   task automatic report_mismatch(string msg);
      errors++;
      if (errors <= MAX_PRINTS) begin
         $display("mismatch at %0t: %s", $realtime, msg);
      end
   endtask

   function automatic rsp_type make_rsp(status_type st, logic signed [VALUE_W-1:0] elem,
                                        int cnt, bit fin);
      rsp_type r;
      r.status      = st;
      r.element     = elem;
      r.entry_count = COUNT_W'(cnt);
      r.last        = fin;
      return r;
   endfunction

   // store mirror, updated once per accepted request
   function automatic void apply_request(req_type rq);
      int p;
      int i;
      int j;
      logic signed [VALUE_W-1:0] key;
      logic signed [VALUE_W-1:0] removed;
      p = int'(rq.position);
      case (rq.kind)
         KIND_APPEND: begin
            if (store_count >= CAP) begin
               pending_rsp.push_back(make_rsp(STATUS_FULL, '0, store_count, 1'b1));
            end else begin
               store_mirror[store_count] = rq.value;
               store_count++;
               pending_rsp.push_back(make_rsp(STATUS_OK, '0, store_count, 1'b1));
            end
         end
         KIND_INSERT: begin
            if (store_count >= CAP) begin
               pending_rsp.push_back(make_rsp(STATUS_FULL, '0, store_count, 1'b1));
            end else if (p < 1 || p > store_count + 1) begin
               pending_rsp.push_back(make_rsp(STATUS_RANGE, '0, store_count, 1'b1));
            end else begin
               for (i = store_count; i >= p; i--) store_mirror[i] = store_mirror[i-1];
               store_mirror[p-1] = rq.value;
               store_count++;
               pending_rsp.push_back(make_rsp(STATUS_OK, '0, store_count, 1'b1));
            end
         end
         KIND_DELETE: begin
            if (store_count == 0) begin
               pending_rsp.push_back(make_rsp(STATUS_EMPTY, '0, store_count, 1'b1));
            end else if (p < 1 || p > store_count) begin
               pending_rsp.push_back(make_rsp(STATUS_RANGE, '0, store_count, 1'b1));
            end else begin
               removed = store_mirror[p-1];
               for (i = p - 1; i + 1 < store_count; i++) store_mirror[i] = store_mirror[i+1];
               store_count--;
               pending_rsp.push_back(make_rsp(STATUS_OK, removed, store_count, 1'b1));
            end
         end
         KIND_SORT: begin
            for (i = 1; i < store_count; i++) begin
               key = store_mirror[i];
               j = i;
               while (j > 0 && key < store_mirror[j-1]) begin
                  store_mirror[j] = store_mirror[j-1];
                  j--;
               end
               store_mirror[j] = key;
            end
            pending_rsp.push_back(make_rsp(STATUS_OK, '0, store_count, 1'b1));
         end
         KIND_DUMP: begin
            n_dump++;
            if (store_count == 0) begin
               pending_rsp.push_back(make_rsp(STATUS_EMPTY, '0, store_count, 1'b1));
            end else begin
               for (i = 0; i < store_count; i++) begin
                  pending_rsp.push_back(make_rsp(STATUS_OK, store_mirror[i], store_count,
                                                 i + 1 == store_count));
               end
            end
         end
         default: begin
            pending_rsp.push_back(make_rsp(STATUS_OK, '0, store_count, 1'b1));
         end
      endcase
      if (store_count > max_count) max_count = store_count;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_payload <= '0;
      end else begin
         if (req_valid && req_ready) begin
            apply_request(req_payload);
            n_req++;
         end
         if (!req_valid || req_ready) begin
            if (feed_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid   <= 1'b1;
               req_payload <= feed_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_req != hold_taken) begin
         hold_taken <= hold_req;
         hold_left  <= HOLD_LEN;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // response monitor
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_rsp++;
            status_seen[rsp_payload.status]++;
            if (pending_rsp.size() == 0) begin
               report_mismatch($sformatf("unexpected response %p", rsp_payload));
            end else begin
               exp_rsp = pending_rsp.pop_front();
               if (rsp_payload.status !== exp_rsp.status)
                  report_mismatch($sformatf("status %0d, want %0d",
                                            rsp_payload.status, exp_rsp.status));
               if (rsp_payload.element !== exp_rsp.element)
                  report_mismatch($sformatf("element %0d, want %0d",
                                            rsp_payload.element, exp_rsp.element));
               if (rsp_payload.entry_count !== exp_rsp.entry_count)
                  report_mismatch($sformatf("entry_count %0d, want %0d",
                                            rsp_payload.entry_count, exp_rsp.entry_count));
               if (rsp_payload.last !== exp_rsp.last)
                  report_mismatch($sformatf("last %0b, want %0b",
                                            rsp_payload.last, exp_rsp.last));
            end
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   function automatic int count_after(kind_type k, int p, int c);
      case (k)
         KIND_APPEND: return (c < CAP) ? c + 1 : c;
         KIND_INSERT: return (c < CAP && p >= 1 && p <= c + 1) ? c + 1 : c;
         KIND_DELETE: return (c > 0 && p >= 1 && p <= c) ? c - 1 : c;
         default:     return c;
      endcase
   endfunction

   task automatic queue_req(kind_type k, logic signed [VALUE_W-1:0] v, int p);
      req_type rq;
      rq.kind     = k;
      rq.value    = v;
      rq.position = POS_W'(p);
      feed_q.push_back(rq);
      gen_count = count_after(k, p, gen_count);
   endtask

   function automatic logic signed [VALUE_W-1:0] rand_value();
      int r;
      r = $urandom_range(0, 9);
      if (r <= 5) return $urandom;
      if (r <= 7) return $signed($urandom_range(0, 20)) - 10;
      if (r == 8) return $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
      return $urandom_range(0, 1) ? -32'sd1 : 32'sd0;
   endfunction

   function automatic int rand_pos(int hi);
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 127);
      return $urandom_range(1, (hi < 1) ? 1 : hi);
   endfunction

   task automatic queue_random(int n);
      int r;
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < 28) queue_req(KIND_APPEND, rand_value(), $urandom_range(0, 127));
         else if (r < 50) queue_req(KIND_INSERT, rand_value(), rand_pos(gen_count + 1));
         else if (r < 72) queue_req(KIND_DELETE, rand_value(), rand_pos(gen_count));
         else if (r < 81) queue_req(KIND_SORT, rand_value(), $urandom_range(0, 127));
         else if (r < 90) queue_req(KIND_DUMP, rand_value(), $urandom_range(0, 127));
         else queue_req(kind_type'(3'($urandom_range(5, 7))), rand_value(),
                        $urandom_range(0, 127));
      end
   endtask

   task automatic drain();
      @(negedge clock);
      while (feed_q.size() != 0 || req_valid || pending_rsp.size() != 0) @(negedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed corners, no idling
      queue_req(KIND_DUMP, 0, 0);
      queue_req(KIND_DELETE, 0, 1);
      queue_req(KIND_SORT, 0, 0);
      queue_req(KIND_APPEND, 32'sh8000_0000, 0);
      queue_req(KIND_APPEND, 32'sh7fff_ffff, 0);
      queue_req(KIND_APPEND, 0, 0);
      queue_req(KIND_APPEND, -1, 0);
      queue_req(KIND_INSERT, 9, 0);
      queue_req(KIND_INSERT, 9, gen_count + 2);
      queue_req(KIND_INSERT, 5, 1);
      queue_req(KIND_INSERT, -7, gen_count + 1);
      queue_req(KIND_INSERT, 32'sh1234_5678, 3);
      queue_req(KIND_DELETE, 0, 0);
      queue_req(KIND_DELETE, 0, gen_count + 1);
      queue_req(KIND_DELETE, 0, 127);
      queue_req(KIND_INSERT, 3, 127);
      queue_req(KIND_DELETE, 0, 1);
      queue_req(KIND_DELETE, 0, gen_count);
      queue_req(KIND_SORT, 0, 0);
      queue_req(KIND_DUMP, 0, 0);
      queue_req(kind_type'(3'd5), 32'sh5a5a_a5a5, 42);
      queue_req(kind_type'(3'd6), 32'sh7fff_ffff, 0);
      queue_req(kind_type'(3'd7), -1, 127);
      queue_req(KIND_DELETE, 0, 3);
      queue_req(KIND_DUMP, 0, 0);
      drain();

      // fill to capacity, then full rejects, full sort, full dump, end deletes and random
      while (gen_count < CAP) begin
         if ($urandom_range(0, 1)) queue_req(KIND_APPEND, rand_value(), 0);
         else queue_req(KIND_INSERT, rand_value(), $urandom_range(1, gen_count + 1));
      end
      queue_req(KIND_APPEND, rand_value(), 0);
      queue_req(KIND_INSERT, rand_value(), 1);
      queue_req(KIND_SORT, 0, 0);
      queue_req(KIND_DUMP, 0, 0);
      queue_req(KIND_DELETE, 0, CAP);
      queue_req(KIND_DELETE, 0, 1);
      queue_random(5);
      drain();

      send_idle_pct = 73;
      rsp_stall_pct = 0;
      queue_random(15);
      drain();

      send_idle_pct = 0;
      rsp_stall_pct = 73;
      hold_req++;
      queue_random(15);
      drain();

      send_idle_pct = 15;
      rsp_stall_pct = 15;
      queue_random(20);
      drain();

      repeat (TAIL_WAIT) @(posedge clock);
      $display("covered %0d requests and %0d responses, %0d dumps, peak entry count %0d",
               n_req, n_rsp, n_dump, max_count);
      $display("responses by status: ok %0d, full %0d, out of range %0d, empty %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
